// ----- hw/rtl/sha512_pkg.sv -----
// Package of SHA-512 constants, types and round helper functions.
package sha512_pkg;

  localparam int unsigned BlockBytes = 128;
  localparam int unsigned Rounds = 80;
  localparam int unsigned LenPos = 112;
  localparam int unsigned QueueDepthDefault = 4;

  // Queue entry passed from the front to the back: one 64-bit message word.
  typedef struct packed {
    logic [63:0] data;
    logic        block_end;   // last word of a 128-byte block
    logic        msg_end;     // that block also ends the message
  } sha512_word_t;

  function automatic logic [63:0] init_hash(input logic [2:0] idx);
    logic [63:0] v;
    unique case (idx)
      3'd0: v = 64'h6a09e667f3bcc908;
      3'd1: v = 64'hbb67ae8584caa73b;
      3'd2: v = 64'h3c6ef372fe94f82b;
      3'd3: v = 64'ha54ff53a5f1d36f1;
      3'd4: v = 64'h510e527fade682d1;
      3'd5: v = 64'h9b05688c2b3e6c1f;
      3'd6: v = 64'h1f83d9abfb41bd6b;
      default: v = 64'h5be0cd19137e2179;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] round_k(input logic [6:0] t);
    logic [63:0] v;
    unique case (t)
      7'd0: v = 64'h428a2f98d728ae22;  7'd1: v = 64'h7137449123ef65cd;
      7'd2: v = 64'hb5c0fbcfec4d3b2f;  7'd3: v = 64'he9b5dba58189dbbc;
      7'd4: v = 64'h3956c25bf348b538;  7'd5: v = 64'h59f111f1b605d019;
      7'd6: v = 64'h923f82a4af194f9b;  7'd7: v = 64'hab1c5ed5da6d8118;
      7'd8: v = 64'hd807aa98a3030242;  7'd9: v = 64'h12835b0145706fbe;
      7'd10: v = 64'h243185be4ee4b28c; 7'd11: v = 64'h550c7dc3d5ffb4e2;
      7'd12: v = 64'h72be5d74f27b896f; 7'd13: v = 64'h80deb1fe3b1696b1;
      7'd14: v = 64'h9bdc06a725c71235; 7'd15: v = 64'hc19bf174cf692694;
      7'd16: v = 64'he49b69c19ef14ad2; 7'd17: v = 64'hefbe4786384f25e3;
      7'd18: v = 64'h0fc19dc68b8cd5b5; 7'd19: v = 64'h240ca1cc77ac9c65;
      7'd20: v = 64'h2de92c6f592b0275; 7'd21: v = 64'h4a7484aa6ea6e483;
      7'd22: v = 64'h5cb0a9dcbd41fbd4; 7'd23: v = 64'h76f988da831153b5;
      7'd24: v = 64'h983e5152ee66dfab; 7'd25: v = 64'ha831c66d2db43210;
      7'd26: v = 64'hb00327c898fb213f; 7'd27: v = 64'hbf597fc7beef0ee4;
      7'd28: v = 64'hc6e00bf33da88fc2; 7'd29: v = 64'hd5a79147930aa725;
      7'd30: v = 64'h06ca6351e003826f; 7'd31: v = 64'h142929670a0e6e70;
      7'd32: v = 64'h27b70a8546d22ffc; 7'd33: v = 64'h2e1b21385c26c926;
      7'd34: v = 64'h4d2c6dfc5ac42aed; 7'd35: v = 64'h53380d139d95b3df;
      7'd36: v = 64'h650a73548baf63de; 7'd37: v = 64'h766a0abb3c77b2a8;
      7'd38: v = 64'h81c2c92e47edaee6; 7'd39: v = 64'h92722c851482353b;
      7'd40: v = 64'ha2bfe8a14cf10364; 7'd41: v = 64'ha81a664bbc423001;
      7'd42: v = 64'hc24b8b70d0f89791; 7'd43: v = 64'hc76c51a30654be30;
      7'd44: v = 64'hd192e819d6ef5218; 7'd45: v = 64'hd69906245565a910;
      7'd46: v = 64'hf40e35855771202a; 7'd47: v = 64'h106aa07032bbd1b8;
      7'd48: v = 64'h19a4c116b8d2d0c8; 7'd49: v = 64'h1e376c085141ab53;
      7'd50: v = 64'h2748774cdf8eeb99; 7'd51: v = 64'h34b0bcb5e19b48a8;
      7'd52: v = 64'h391c0cb3c5c95a63; 7'd53: v = 64'h4ed8aa4ae3418acb;
      7'd54: v = 64'h5b9cca4f7763e373; 7'd55: v = 64'h682e6ff3d6b2b8a3;
      7'd56: v = 64'h748f82ee5defb2fc; 7'd57: v = 64'h78a5636f43172f60;
      7'd58: v = 64'h84c87814a1f0ab72; 7'd59: v = 64'h8cc702081a6439ec;
      7'd60: v = 64'h90befffa23631e28; 7'd61: v = 64'ha4506cebde82bde9;
      7'd62: v = 64'hbef9a3f7b2c67915; 7'd63: v = 64'hc67178f2e372532b;
      7'd64: v = 64'hca273eceea26619c; 7'd65: v = 64'hd186b8c721c0c207;
      7'd66: v = 64'heada7dd6cde0eb1e; 7'd67: v = 64'hf57d4f7fee6ed178;
      7'd68: v = 64'h06f067aa72176fba; 7'd69: v = 64'h0a637dc5a2c898a6;
      7'd70: v = 64'h113f9804bef90dae; 7'd71: v = 64'h1b710b35131c471b;
      7'd72: v = 64'h28db77f523047d84; 7'd73: v = 64'h32caab7b40c72493;
      7'd74: v = 64'h3c9ebe0a15c9bebc; 7'd75: v = 64'h431d67c49c100d4c;
      7'd76: v = 64'h4cc5d4becb3e42b6; 7'd77: v = 64'h597f299cfc657e2a;
      7'd78: v = 64'h5fcb6fab3ad6faec; 7'd79: v = 64'h6c44198c4a475817;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage

// ----- hw/rtl/sha512_front.sv -----
// Front end: packs bytes into big-endian 64-bit words and generates padding.
module sha512_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                data_byte,
  input  logic                      byte_present,
  input  logic                      end_of_message,
  output logic                      wr_valid,
  input  logic                      wr_ready,
  output sha512_pkg::sha512_word_t  wr_word
);
  import sha512_pkg::*;

  typedef enum logic [1:0] {ST_BYTES, ST_PAD, ST_LEN} state_t;

  state_t      state;
  logic [6:0]  pos;        // byte position inside the block
  logic [63:0] acc;        // word under assembly
  logic [63:0] bit_len;
  logic        pad_first;  // the 0x80 byte has not been placed yet

  logic        take;
  logic        bp;
  logic [63:0] acc_byte;
  logic [63:0] len_next;
  logic [3:0]  word_pos;
  logic [3:0]  word_inc;

  assign in_ready = (state == ST_BYTES) && (!byte_present || pos[2:0] != 3'd7 || wr_ready);
  assign take     = in_valid && in_ready;
  assign bp       = byte_present;
  assign acc_byte = {acc[55:0], data_byte};
  assign len_next = bit_len + 64'd8;
  assign word_pos = pos[6:3];
  assign word_inc = pos[6:3] + 4'd1;

  always_comb begin
    wr_valid = 1'b0;
    wr_word  = '0;
    unique case (state)
      ST_BYTES: begin
        wr_valid          = in_valid && bp && pos[2:0] == 3'd7;
        wr_word.data      = acc_byte;
        wr_word.block_end = (pos == 7'd127);
      end
      ST_PAD: begin
        // The first padding word holds the partial bytes, then 0x80, then zeros.
        wr_valid          = 1'b1;
        wr_word.data      = pad_first ? ({acc[55:0], 8'h80} << {~pos[2:0], 3'b000}) : 64'd0;
        wr_word.block_end = (word_pos == 4'd15);
      end
      default: begin
        wr_valid          = 1'b1;
        wr_word.data      = (word_pos == 4'd15) ? bit_len : 64'd0;
        wr_word.block_end = (word_pos == 4'd15);
        wr_word.msg_end   = (word_pos == 4'd15);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_BYTES;
      pos       <= '0;
      acc       <= '0;
      bit_len   <= '0;
      pad_first <= 1'b0;
    end else begin
      unique case (state)
        ST_BYTES: begin
          if (take) begin
            if (bp) begin
              acc     <= acc_byte;
              pos     <= pos + 7'd1;
              bit_len <= len_next;
            end
            if (end_of_message) begin
              state     <= ST_PAD;
              pad_first <= 1'b1;
            end
          end
        end
        ST_PAD: begin
          // Zero words run up to word 13; words 14 and 15 carry the length.
          if (wr_ready) begin
            pad_first <= 1'b0;
            pos       <= {word_inc, 3'b000};
            if (word_pos == 4'd13) state <= ST_LEN;
          end
        end
        default: begin
          if (wr_ready) begin
            if (word_pos == 4'd15) begin
              state   <= ST_BYTES;
              pos     <= '0;
              bit_len <= '0;
            end else begin
              pos <= {word_inc, 3'b000};
            end
          end
        end
      endcase
    end
  end

  wire pad_len_slot = (state == ST_PAD) && (pos[6:3] == 4'd13);

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEN) |-> (pos[6:3] == 4'd14 || pos[6:3] == 4'd15))
    else $error("length words out of place");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEN) |-> !pad_first)
    else $error("length started before the pad byte");
  assert property (@(posedge clk) disable iff (rst)
    pad_len_slot && wr_valid && wr_ready |=> state == ST_LEN)
    else $error("missed length words");
endmodule

// ----- hw/rtl/sha512_queue.sv -----
// Small word queue between the front end and the compression core.
module sha512_queue #(
  parameter int unsigned Depth = sha512_pkg::QueueDepthDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_valid,
  output logic                      wr_ready,
  input  sha512_pkg::sha512_word_t  wr_word,
  output logic                      rd_valid,
  input  logic                      rd_ready,
  output sha512_pkg::sha512_word_t  rd_word
);
  import sha512_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  sha512_word_t      mem [Depth];
  logic [AW-1:0]     wp, rp;
  logic [AW:0]       count;
  logic              push, pop;

  assign wr_ready = (count != (AW+1)'(Depth));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_word  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == AW'(Depth - 1)) ? '0 : wp + AW'(1);
      if (pop)  rp <= (rp == AW'(Depth - 1)) ? '0 : rp + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= (AW+1)'(Depth))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) (count == '0) |-> !pop)
    else $error("queue underflow");
  assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + (AW+1)'(1))
    else $error("queue count slip");
endmodule

// ----- hw/rtl/sha512_core.sv -----
// Compression core: one round per cycle when fed; registered digest output.
module sha512_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_valid,
  output logic                      rd_ready,
  input  sha512_pkg::sha512_word_t  rd_word,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [63:0]               out_word,
  output logic [2:0]                out_index,
  output logic                      out_last
);
  import sha512_pkg::*;

  typedef enum logic [1:0] {ST_LOAD, ST_ROUND, ST_ADD, ST_EMIT} state_t;

  state_t      state;
  logic [63:0] hw [8];
  logic [63:0] a, b, c, d, e, f, g, h;
  logic [63:0] win [16];
  logic [6:0]  rnd;
  logic        msg_end;
  logic [2:0]  emit_idx;

  logic [63:0] w, w2, w15, s0, s1, t1, t2;
  logic        step;

  assign rd_ready = (state == ST_LOAD || state == ST_ROUND) && rnd < 7'd16;
  assign step = (state == ST_LOAD || state == ST_ROUND) &&
                (rnd >= 7'd16 || rd_valid);

  always_comb begin
    w2  = win[4'(rnd - 7'd2)];
    w15 = win[4'(rnd - 7'd15)];
    s1  = rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6);
    s0  = rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7);
    if (rnd < 7'd16)
      w = rd_word.data;
    else
      w = s1 + win[4'(rnd - 7'd7)] + s0 + win[rnd[3:0]];
    t1 = h + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41)) + ((e & f) ^ (~e & g))
         + round_k(rnd) + w;
    t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
  end

  always_ff @(posedge clk) begin
    if (step) win[rnd[3:0]] <= w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      rnd       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) hw[i] <= init_hash(3'(i));
      {a, b, c, d, e, f, g, h} <= '0;
    end else begin
      unique case (state)
        ST_LOAD, ST_ROUND: begin
          if (step) begin
            if (rnd == 7'd0) begin
              // First round works on the current hash directly.
              h <= hw[6]; g <= hw[5]; f <= hw[4];
              e <= hw[3] + (hw[7] + (rotr(hw[4], 14) ^ rotr(hw[4], 18) ^ rotr(hw[4], 41))
                   + ((hw[4] & hw[5]) ^ (~hw[4] & hw[6])) + round_k(rnd) + w);
              d <= hw[2]; c <= hw[1]; b <= hw[0];
              a <= (hw[7] + (rotr(hw[4], 14) ^ rotr(hw[4], 18) ^ rotr(hw[4], 41))
                   + ((hw[4] & hw[5]) ^ (~hw[4] & hw[6])) + round_k(rnd) + w)
                   + ((rotr(hw[0], 28) ^ rotr(hw[0], 34) ^ rotr(hw[0], 39))
                   + ((hw[0] & hw[1]) ^ (hw[0] & hw[2]) ^ (hw[1] & hw[2])));
              state <= ST_ROUND;
            end else begin
              h <= g; g <= f; f <= e; e <= d + t1;
              d <= c; c <= b; b <= a; a <= t1 + t2;
            end
            if (rnd == 7'd15) msg_end <= rd_word.msg_end;
            if (rnd == 7'(Rounds - 1)) begin
              rnd   <= '0;
              state <= ST_ADD;
            end else begin
              rnd <= rnd + 7'd1;
            end
          end
        end
        ST_ADD: begin
          hw[0] <= hw[0] + a; hw[1] <= hw[1] + b; hw[2] <= hw[2] + c; hw[3] <= hw[3] + d;
          hw[4] <= hw[4] + e; hw[5] <= hw[5] + f; hw[6] <= hw[6] + g; hw[7] <= hw[7] + h;
          emit_idx <= '0;
          state <= msg_end ? ST_EMIT : ST_LOAD;
        end
        default: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_word  <= hw[emit_idx];
            out_index <= emit_idx;
            out_last  <= (emit_idx == 3'd7);
            emit_idx  <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) hw[i] <= init_hash(3'(i));
              state <= ST_LOAD;
            end
          end
        end
      endcase
      if (state != ST_EMIT && out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) rnd < 7'(Rounds))
    else $error("round counter out of range");
  assert property (@(posedge clk) disable iff (rst)
    (rd_valid && rd_ready && rnd == 7'd15) |-> rd_word.block_end)
    else $error("block boundary mismatch");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> !(rd_ready && rnd >= 7'd16))
    else $error("schedule read while expanding");
endmodule

// ----- hw/rtl/sha512_stream_hasher.sv -----
// SHA-512 stream hasher: byte-in stream, eight digest words out per message.
// Each input word carries one message byte when tuser is high, or none, and tlast ends the
// message; the eight digest words follow most significant first, with tlast on the eighth.
// Bytes are packed into 64-bit words that pass a short queue to a core running one round per
// cycle when fed. The core takes one queued word per round for rounds 0 to 15 and nothing
// during rounds 16 to 79 or the hash addition; the default four-word queue holds 32 bytes,
// so with bytes arriving every cycle the input stalls once the queue fills while the core
// works through those rounds. After an end mark the input is held off until the last padding
// and length word is queued: up to 18 words when the padding spills into a second block. The
// digest follows the final block's rounds and hash addition, one word per cycle while the
// receiver is ready; a stalled receiver backs up into the input.
module sha512_stream_hasher #(
  parameter int unsigned QueueDepth = sha512_pkg::QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tuser,   // byte_present
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // digest_word[63:0], word_index[66:64]
  output logic        m_axis_tlast    // last_word
);
  import sha512_pkg::*;

  logic         wr_valid, wr_ready, rd_valid, rd_ready;
  sha512_word_t wr_word, rd_word;
  logic [63:0]  dw;
  logic [2:0]   idx;

  sha512_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .data_byte(s_axis_tdata), .byte_present(s_axis_tuser),
    .end_of_message(s_axis_tlast),
    .wr_valid, .wr_ready, .wr_word
  );

  sha512_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst, .wr_valid, .wr_ready, .wr_word, .rd_valid, .rd_ready, .rd_word
  );

  sha512_core u_core (
    .clk, .rst, .rd_valid, .rd_ready, .rd_word,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_word(dw), .out_index(idx), .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, idx, dw};
endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the SHA-512 stream hasher with a built-in digest predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sha512_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;

  sha512_stream_hasher u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } msg_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_out_t;

  localparam logic [63:0] H0 [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  localparam logic [63:0] KTAB [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

  // Predictor state.
  logic [63:0] chain [8];
  logic [7:0]  blk [BlockBytes];
  logic [63:0] msg_bits;
  int unsigned fill;

  digest_out_t digest_q[$];
  msg_item_t   stim_q[$];
  int          errors;
  int          words_seen;
  longint      cycles;
  bit          stim_done;
  bit          hold_off;

  function automatic logic [63:0] ror(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic queue_item(msg_item_t it);
    stim_q.insert(stim_q.size(), it);
  endtask

  task automatic expect_word(digest_out_t d);
    digest_q.insert(digest_q.size(), d);
  endtask

  task automatic run_block();
    logic [63:0] w [80];
    logic [63:0] v [8];
    logic [63:0] t1, t2;
    for (int t = 0; t < 16; t++) begin
      w[t] = '0;
      for (int j = 0; j < 8; j++) w[t] = {w[t][55:0], blk[t*8+j]};
    end
    for (int t = 16; t < 80; t++)
      w[t] = (ror(w[t-2], 19) ^ ror(w[t-2], 61) ^ (w[t-2] >> 6)) + w[t-7]
           + (ror(w[t-15], 1) ^ ror(w[t-15], 8) ^ (w[t-15] >> 7)) + w[t-16];
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 80; t++) begin
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[t] + w[t];
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) chain[i] = H0[i];
    for (int i = 0; i < BlockBytes; i++) blk[i] = '0;
    msg_bits = '0;
    fill = 0;
  endtask

  task automatic predict_digest(msg_item_t it);
    if (it.byte_present) begin
      blk[fill] = it.data_byte;
      fill++;
      msg_bits += 64'd8;
      if (fill == BlockBytes) begin
        run_block();
        fill = 0;
      end
    end
    if (it.end_of_message) begin
      blk[fill] = 8'h80;
      fill++;
      for (int i = fill; i < BlockBytes; i++) blk[i] = '0;
      if (fill > LenPos) begin
        run_block();
        for (int i = 0; i < BlockBytes; i++) blk[i] = '0;
      end
      for (int i = 0; i < 8; i++) blk[LenPos + 8 + i] = msg_bits[63 - 8*i -: 8];
      run_block();
      for (int i = 0; i < 8; i++) expect_word({chain[i], 3'(i), i == 7});
      restart_message();
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  task automatic add_msg(int len, bit fixed, logic [7:0] val, bit tail_on_last);
    msg_item_t it;
    for (int i = 0; i < len; i++) begin
      it.data_byte = fixed ? val : 8'($urandom);
      it.byte_present = 1'b1;
      it.end_of_message = tail_on_last && (i == len - 1);
      queue_item(it);
    end
    if (!tail_on_last || len == 0) queue_item(msg_item_t'{8'($urandom), 1'b0, 1'b1});
  endtask

  // Directed rows: byte value, byte flag, end flag.
  msg_item_t directed [9] = '{
    '{8'h00, 1'b0, 1'b1},   // empty message
    '{8'h61, 1'b1, 1'b0},
    '{8'h62, 1'b1, 1'b0},
    '{8'h63, 1'b1, 1'b1},   // "abc", byte together with end mark
    '{8'hff, 1'b0, 1'b0},   // neither flag: ignored
    '{8'hff, 1'b1, 1'b0},
    '{8'h00, 1'b1, 1'b0},
    '{8'h5a, 1'b0, 1'b1},   // end mark alone after bytes
    '{8'ha5, 1'b0, 1'b1}
  };

  // Known digest of the empty message, word 0, and of "abc", word 0.
  localparam logic [63:0] EMPTY_W0 = 64'hcf83e1357eefb8bd;
  localparam logic [63:0] ABC_W0   = 64'hddaf35a193617aba;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int r;
    restart_message();
    foreach (directed[i]) queue_item(directed[i]);
    // Pad byte in word 13, pad byte at 112 spilling into a second block, and a full block
    // whose last byte carries the end mark.
    add_msg(104, 1'b1, 8'h00, 1'b1);
    add_msg(112, 1'b1, 8'hff, 1'b1);
    add_msg(128, 1'b0, 8'h00, 1'b1);
    while (stim_q.size() < 375) begin
      r = $urandom_range(0, 9);
      if (r == 0) queue_item(msg_item_t'{8'($urandom), 1'b0, 1'b0});
      else add_msg($urandom_range(0, 12), 1'b0, 8'h00, 1'($urandom_range(0, 1)));
    end
    queue_item(msg_item_t'{8'h00, 1'b0, 1'b1});
  end

  // Sender: bursts with gaps; predicts on acceptance.
  initial begin
    int burst;
    msg_item_t cur;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    errors = 0;
    words_seen = 0;
    stim_done = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (stim_q.size() > 0) begin
      burst = $urandom_range(1, 60);
      while (burst > 0 && stim_q.size() > 0) begin
        cur = stim_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= cur.data_byte;
        s_axis_tuser <= cur.byte_present;
        s_axis_tlast <= cur.end_of_message;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_digest(cur);
        burst--;
      end
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1;
  end

  // Receiver stall pattern, plus one long hold-off early on.
  initial begin
    int k;
    m_axis_tready = 1'b0;
    hold_off = 0;
    k = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      k++;
      if (k == 300) hold_off = 1;
      if (k == 900) hold_off = 0;
      if (hold_off) m_axis_tready <= 1'b0;
      else if ((k / 400) % 3 == 0) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    digest_out_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[63:0], m_axis_tdata[66:64], m_axis_tlast};
      // The first two messages have well-known digests.
      if (words_seen == 0 && got.digest_word !== EMPTY_W0)
        report_mismatch("empty message word 0", got.digest_word, EMPTY_W0);
      if (words_seen == 8 && got.digest_word !== ABC_W0)
        report_mismatch("abc word 0", got.digest_word, ABC_W0);
      words_seen++;
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected digest word", got.digest_word, '0);
      end else begin
        want = digest_q.pop_front();
        if (got.digest_word !== want.digest_word)
          report_mismatch("digest_word", got.digest_word, want.digest_word);
        if (got.word_index !== want.word_index)
          report_mismatch("word_index", 64'(got.word_index), 64'(want.word_index));
        if (got.last_word !== want.last_word)
          report_mismatch("last_word", 64'(got.last_word), 64'(want.last_word));
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 200000) begin
        $display("sha512_stream_hasher regression: fail");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    while (digest_q.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("sha512_stream_hasher regression: pass");
    end else begin
      $display("sha512_stream_hasher regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/sha512_pkg.sv
hw/rtl/sha512_front.sv
hw/rtl/sha512_queue.sv
hw/rtl/sha512_core.sv
hw/rtl/sha512_stream_hasher.sv
tb/sv/testbench.sv
